// ===== hw/rtl/pnsi_pkg.sv =====
// ----------------------------------------------------------------------------
// pnsi_pkg: shared types and constants
// Widths, request/response payload types and sequencer states for the
// polyline nearest segment block.
// ----------------------------------------------------------------------------
package pnsi_pkg;
   localparam int MaxVertices = 256;
   localparam int IdxW        = $clog2(MaxVertices);
   localparam int CntW        = IdxW + 1;
   localparam int CoordW      = 16;
   localparam int CsrIdxW     = 2;

   localparam logic [CsrIdxW-1:0] CSR_START_X = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_START_Y = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_END_X   = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_END_Y   = 2'd3;

   typedef struct packed {
      logic                     req_type;
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
   } req_type_type;

   typedef struct packed {
      logic [7:0] nearest_vertex;
      logic [7:0] nearest_segment;
      logic [8:0] vertex_count;
      logic       inserted;
      logic       store_full;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_A, ST_RD_B, ST_VTX, ST_SEG0, ST_SEG1, ST_DIV, ST_SEG2,
      ST_SEG3, ST_SEG4, ST_SHIFT_RD, ST_SHIFT_WR, ST_PUT, ST_RSP,
      ST_INIT0, ST_INIT1
   } state_type;
endpackage

// ===== hw/rtl/pnsi_stream_if.sv =====
// ----------------------------------------------------------------------------
// pnsi_stream_if: valid/ready channel
// Carries one payload transaction per valid and ready handshake.
// ----------------------------------------------------------------------------
interface pnsi_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/polyline_nearest_segment_insert.sv =====
// ----------------------------------------------------------------------------
// polyline_nearest_segment_insert: nearest vertex and segment search
// Walks the stored polyline with one shared multiplier path and a radix-2
// divider, then shifts entries up to make room for an insert.
// ----------------------------------------------------------------------------
// Each segment is searched in turn, using the 16-step divider only when the
// projection falls strictly inside the segment; an insert at place p then
// shifts the entries from p upward. The next transaction is taken in the cycle
// after the response is produced; a response not yet taken stalls the next one.
// Reset: synchronous; the start and end points are written to the store in
// ST_INIT0 then ST_INIT1 after reset, count is 2.
module polyline_nearest_segment_insert (
   input  logic                        clock,
   input  logic                        reset,
   pnsi_stream_if.sink                 req,
   pnsi_stream_if.source               rsp,
   input  logic                        csr_wr_en,
   input  logic [pnsi_pkg::CsrIdxW-1:0] csr_index,
   input  logic [15:0]                 csr_wr_data
);
   import pnsi_pkg::*;

   state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic            ins_ff, ins_in;
   logic            full_ff, full_in;
   logic signed [CoordW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [CoordW-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [17:0] qx_ff, qx_in, qy_ff, qy_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [34:0] len2_ff, len2_in;
   logic [16:0] t_ff, t_in;
   logic [51:0] rem_ff, rem_in;
   logic [4:0]  step_ff, step_in;
   logic signed [35:0] mx_ff, mx_in, my_ff, my_in;
   logic [36:0] bv_ff, bv_in, bs_ff, bs_in;
   logic        bvv_ff, bvv_in, bsv_ff, bsv_in;
   logic [IdxW-1:0] iv_ff, iv_in, is_ff, is_in;
   logic [CntW-1:0] sh_ff, sh_in;
   logic [CoordW-1:0] stx_ff, stx_in, sty_ff, sty_in, enx_ff, enx_in, eny_ff, eny_in;
   rsp_type rsp_ff, rsp_in;
   logic    rv_ff, rv_in;

   logic [IdxW-1:0] rd_addr, wr_addr;
   logic            wr_en_x, wr_en_y;
   logic [CoordW-1:0] wx, wy, rx, ry;

   pnsi_ram #(.Width(CoordW), .Depth(MaxVertices)) u_ram_x (
      .clock, .wr_en(wr_en_x), .wr_addr, .wr_data(wx), .rd_addr, .rd_data(rx));
   pnsi_ram #(.Width(CoordW), .Depth(MaxVertices)) u_ram_y (
      .clock, .wr_en(wr_en_y), .wr_addr, .wr_data(wy), .rd_addr, .rd_data(ry));

   logic [CntW-1:0] last;
   logic signed [17:0] ex, ey;
   logic [36:0] dsum;
   logic signed [36:0] dot_sum;
   logic signed [52:0] rem_try;
   logic signed [35:0] rx_sum, ry_sum;
   logic [IdxW-1:0] pos;
   logic signed [17:0] mul_ax, mul_bx, mul_ay, mul_by;
   logic signed [35:0] prod_x, prod_y;

   assign last  = count_ff - CntW'(1);
   assign pos   = is_ff + IdxW'(1);
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.data  = rsp_ff;

   // shared multiplier pair, operands picked by the sequencer
   assign prod_x = 36'(mul_ax) * 36'(mul_bx);
   assign prod_y = 36'(mul_ay) * 36'(mul_by);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT0;
         count_ff <= CntW'(2);
         rv_ff    <= 1'b0;
         stx_ff   <= '0;
         sty_ff   <= '0;
         enx_ff   <= CoordW'(16384);
         eny_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
         stx_ff   <= stx_in;
         sty_ff   <= sty_in;
         enx_ff   <= enx_in;
         eny_ff   <= eny_in;
      end
      idx_ff <= idx_in; ins_ff <= ins_in; px_ff <= px_in; py_ff <= py_in;
      ax_ff <= ax_in; ay_ff <= ay_in; qx_ff <= qx_in; qy_ff <= qy_in;
      dx_ff <= dx_in; dy_ff <= dy_in; len2_ff <= len2_in;
      t_ff <= t_in; rem_ff <= rem_in; step_ff <= step_in; mx_ff <= mx_in;
      my_ff <= my_in; bv_ff <= bv_in; bs_ff <= bs_in; bvv_ff <= bvv_in;
      bsv_ff <= bsv_in; iv_ff <= iv_in; is_ff <= is_in; sh_ff <= sh_in;
      full_ff <= full_in; rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; ins_in = ins_ff;
      px_in = px_ff; py_in = py_ff; ax_in = ax_ff; ay_in = ay_ff;
      qx_in = qx_ff; qy_in = qy_ff; dx_in = dx_ff; dy_in = dy_ff;
      len2_in = len2_ff; t_in = t_ff; rem_in = rem_ff;
      step_in = step_ff; mx_in = mx_ff; my_in = my_ff; bv_in = bv_ff;
      bs_in = bs_ff; bvv_in = bvv_ff; bsv_in = bsv_ff; iv_in = iv_ff;
      is_in = is_ff; sh_in = sh_ff; rsp_in = rsp_ff; rv_in = rv_ff;
      full_in = full_ff;
      stx_in = stx_ff; sty_in = sty_ff; enx_in = enx_ff; eny_in = eny_ff;
      rd_addr = idx_ff[IdxW-1:0]; wr_en_x = 1'b0; wr_en_y = 1'b0; wr_addr = '0;
      wx = '0; wy = '0;
      ex = '0; ey = '0; dsum = '0; dot_sum = '0; rem_try = '0;
      rx_sum = '0; ry_sum = '0;
      mul_ax = '0; mul_bx = '0; mul_ay = '0; mul_by = '0;

      if (rv_ff && rsp.ready) begin
         rv_in = 1'b0;
      end

      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_X: stx_in = csr_wr_data;
            CSR_START_Y: sty_in = csr_wr_data;
            CSR_END_X:   enx_in = csr_wr_data;
            CSR_END_Y:   eny_in = csr_wr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_INIT0: begin
            // a register write restarts the endpoint load
            if (!csr_wr_en) begin
               wr_en_x = 1'b1; wr_en_y = 1'b1; wr_addr = '0;
               wx = stx_ff; wy = sty_ff;
               state_in = ST_INIT1;
            end
         end
         ST_INIT1: begin
            if (csr_wr_en) begin
               state_in = ST_INIT0;
            end else begin
               wr_en_x = 1'b1; wr_en_y = 1'b1; wr_addr = IdxW'(1);
               wx = enx_ff; wy = eny_ff;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (csr_wr_en) begin
               wx = csr_wr_data; wy = csr_wr_data;
               case (csr_index)
                  CSR_START_X: begin
                     wr_en_x = 1'b1; wr_addr = '0;
                  end
                  CSR_START_Y: begin
                     wr_en_y = 1'b1; wr_addr = '0;
                  end
                  CSR_END_X: begin
                     wr_en_x = 1'b1; wr_addr = last[IdxW-1:0];
                  end
                  CSR_END_Y: begin
                     wr_en_y = 1'b1; wr_addr = last[IdxW-1:0];
                  end
                  default: ;
               endcase
            end
            if (req.valid && req.ready) begin
               ins_in = req.data.req_type;
               px_in = req.data.point_x; py_in = req.data.point_y;
               idx_in = '0; bvv_in = 1'b0; bsv_in = 1'b0;
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            // issue read of vertex idx; data lands next cycle
            state_in = ST_VTX;
         end
         ST_VTX: begin
            ex = 18'(px_ff) - 18'(signed'(rx));
            ey = 18'(py_ff) - 18'(signed'(ry));
            ax_in = rx; ay_in = ry; qx_in = ex; qy_in = ey;
            mul_ax = ex; mul_bx = ex; mul_ay = ey; mul_by = ey;
            mx_in = prod_x; my_in = prod_y;
            if (idx_ff == last) begin
               state_in = ST_SEG4; step_in = 5'd31;
            end else begin
               rd_addr = IdxW'(idx_ff + CntW'(1));
               state_in = ST_RD_B; step_in = 5'd31;
            end
         end
         ST_RD_B: begin
            dsum = 37'(mx_ff) + 37'(my_ff);
            if (!bvv_ff || dsum < bv_ff) begin
               bv_in = dsum; iv_in = idx_ff[IdxW-1:0]; bvv_in = 1'b1;
            end
            rd_addr = IdxW'(idx_ff + CntW'(1));
            state_in = ST_SEG0;
         end
         ST_SEG0: begin
            dx_in = 18'(signed'(rx)) - 18'(ax_ff);
            dy_in = 18'(signed'(ry)) - 18'(ay_ff);
            state_in = ST_SEG1; step_in = '0;
         end
         ST_SEG1: begin
            // squares, then dot product terms, then the clamp of t
            if (step_ff == 5'd0) begin
               mul_ax = dx_ff; mul_bx = dx_ff; mul_ay = dy_ff; mul_by = dy_ff;
               mx_in = prod_x; my_in = prod_y;
               step_in = 5'd1;
            end else if (step_ff == 5'd1) begin
               len2_in = 35'(mx_ff) + 35'(my_ff);
               mul_ax = qx_ff; mul_bx = dx_ff; mul_ay = qy_ff; mul_by = dy_ff;
               mx_in = prod_x; my_in = prod_y;
               step_in = 5'd2;
            end else begin
               dot_sum = 37'(mx_ff) + 37'(my_ff);
               step_in = '0;
               if (len2_ff == '0 || dot_sum <= 37'sd0) begin
                  t_in = '0; state_in = ST_SEG2;
               end else if (dot_sum >= $signed({2'b00, len2_ff})) begin
                  t_in = 17'h10000; state_in = ST_SEG2;
               end else begin
                  t_in = '0;
                  rem_in = 52'(dot_sum);
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit a cycle, 16 fraction bits
            rem_try = $signed({1'b0, rem_ff[50:0], 1'b0}) - $signed(53'(len2_ff));
            if (!rem_try[52]) begin
               rem_in = rem_try[51:0]; t_in = {t_ff[15:0], 1'b1};
            end else begin
               rem_in = {rem_ff[50:0], 1'b0}; t_in = {t_ff[15:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd15) state_in = ST_SEG2;
         end
         ST_SEG2: begin
            mul_ax = dx_ff; mul_bx = $signed({1'b0, t_ff});
            mul_ay = dy_ff; mul_by = $signed({1'b0, t_ff});
            mx_in = prod_x; my_in = prod_y;
            state_in = ST_SEG3;
         end
         ST_SEG3: begin
            rx_sum = mx_ff + 36'sd32768;
            ry_sum = my_ff + 36'sd32768;
            ex = qx_ff - 18'(rx_sum >>> 16);
            ey = qy_ff - 18'(ry_sum >>> 16);
            mul_ax = ex; mul_bx = ex; mul_ay = ey; mul_by = ey;
            mx_in = prod_x; my_in = prod_y;
            step_in = '0;
            state_in = ST_SEG4;
         end
         ST_SEG4: begin
            if (step_ff == 5'd31) begin
               // last vertex: fold its distance, search done
               dsum = 37'(mx_ff) + 37'(my_ff);
               if (!bvv_ff || dsum < bv_ff) begin
                  iv_in = idx_ff[IdxW-1:0];
               end
               full_in = ins_ff && (count_ff >= CntW'(MaxVertices));
               if (ins_ff && count_ff < CntW'(MaxVertices)) begin
                  sh_in = last; rd_addr = last[IdxW-1:0];
                  state_in = ST_SHIFT_WR;
               end else begin
                  state_in = ST_RSP;
               end
            end else begin
               dsum = 37'(mx_ff) + 37'(my_ff);
               if (!bsv_ff || dsum < bs_ff) begin
                  bs_in = dsum; is_in = idx_ff[IdxW-1:0]; bsv_in = 1'b1;
               end
               idx_in = idx_ff + CntW'(1);
               rd_addr = IdxW'(idx_ff + CntW'(1));
               state_in = ST_RD_A;
            end
         end
         ST_SHIFT_RD: begin
            rd_addr = sh_ff[IdxW-1:0];
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            wr_en_x = 1'b1; wr_en_y = 1'b1; wr_addr = IdxW'(sh_ff + CntW'(1));
            wx = rx; wy = ry;
            if (sh_ff[IdxW-1:0] == pos) begin
               state_in = ST_PUT;
            end else begin
               sh_in = sh_ff - CntW'(1);
               rd_addr = IdxW'(sh_ff - CntW'(1));
               state_in = ST_SHIFT_RD;
            end
         end
         ST_PUT: begin
            wr_en_x = 1'b1; wr_en_y = 1'b1; wr_addr = pos; wx = px_ff; wy = py_ff;
            count_in = count_ff + CntW'(1);
            state_in = ST_RSP;
         end
         ST_RSP: begin
            // hold until the previous response is taken
            if (!rv_ff) begin
               rsp_in.nearest_vertex  = 8'(iv_ff);
               rsp_in.nearest_segment = 8'(is_ff);
               rsp_in.vertex_count    = 9'(count_ff);
               rsp_in.inserted        = ins_ff && !full_ff;
               rsp_in.store_full      = full_ff;
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== hw/rtl/pnsi_ram.sv =====
// ----------------------------------------------------------------------------
// pnsi_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pnsi_ram #(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
